@@ rtl/ofd_pkg.sv @@
// ----------------------------------------------------------------------------
// ofd_pkg
// shared types and constants of the occupancy frontier detector
// ----------------------------------------------------------------------------
`default_nettype none

package ofd_pkg;

    localparam int CELL_W  = 8;   // signed occupancy value
    localparam int CFG_W   = 11;  // width and height registers
    localparam int MINU_W  = 4;   // minimum unknown neighbour count
    localparam int COORD_W = 10;  // reported column and row
    localparam int TOTAL_W = 20;  // frontier total
    localparam int CLS_W   = 2;   // cell class
    localparam int WIN_W   = 9 * CLS_W;
    localparam int CIDX_W  = 2;   // configuration register index

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [CFG_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 11'd1024;
    localparam logic [MINU_W-1:0] MINU_RST   = 4'd2;

    typedef enum logic [CLS_W-1:0] {
        CLS_FREE     = 2'd0,
        CLS_UNKNOWN  = 2'd1,
        CLS_OCCUPIED = 2'd2
    } t_cls;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MAP_WIDTH   = 2'd0,
        CFG_MAP_HEIGHT  = 2'd1,
        CFG_MIN_UNKNOWN = 2'd2
    } t_cfg_idx;

    // position of the window centre for one accepted item
    typedef struct packed {
        logic               interior;  // centre lies inside the map border
        logic               last;      // item is the map's last cell
        logic [COORD_W-1:0] col;       // centre column
        logic [COORD_W-1:0] row;       // centre row
    } t_pos;

    function automatic t_cls classify(input logic signed [CELL_W-1:0] v);
        t_cls c;
        if (v == -8'sd1) begin
            c = CLS_UNKNOWN;
        end else if (v == 8'sd0) begin
            c = CLS_FREE;
        end else begin
            c = CLS_OCCUPIED;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/occupancy_frontier_detector.sv @@
// ----------------------------------------------------------------------------
// occupancy_frontier_detector
// streams raster occupancy cells and reports free interior cells with
// enough unknown neighbours, plus a done marker with a total per map
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  cell     in         i_cell_valid / o_cell_ready i_cell_value
//  result   out        o_res_valid / i_res_ready   o_frontier_col, o_frontier_row,
//                                                  o_found, o_map_done,
//                                                  o_frontier_total
//  config   in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  one item per cycle sustained unless a waiting result stalls it; an accepted
//  item is registered in the window register, then its result in the result
//  register, which drives the outputs
//  line store read is issued one column ahead through a registered ram port
//  reset is synchronous, active low; line stores and window are not cleared
//  a waiting result stalls the window stage only when that stage holds an
//  item that yields a result; config writes land at the end of each valid cycle
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_frontier_detector #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // cell stream
    input  wire                              i_cell_valid,
    output logic                             o_cell_ready,
    input  wire signed [ofd_pkg::CELL_W-1:0] i_cell_value,
    // results
    output logic                             o_res_valid,
    input  wire                              i_res_ready,
    output logic [ofd_pkg::COORD_W-1:0]      o_frontier_col,
    output logic [ofd_pkg::COORD_W-1:0]      o_frontier_row,
    output logic                             o_found,
    output logic                             o_map_done,
    output logic [ofd_pkg::TOTAL_W-1:0]      o_frontier_total,
    // configuration writes
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [ofd_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire [ofd_pkg::CFG_W-1:0]         i_cfg_data
);
    import ofd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // configuration registers
    logic [CFG_W-1:0]   r_map_width;
    logic [CFG_W-1:0]   r_map_height;
    logic [MINU_W-1:0]  r_min_unknown;

    // window stage
    logic               r_a_valid;
    logic [WIN_W-1:0]   r_win;
    t_pos               r_pos;
    logic [WIN_W-1:0]   n_win;

    logic               accept;
    logic               take;
    t_cls               cur_cls;
    t_cls               up_cls;
    t_cls               mid_cls;
    logic [CW-1:0]      col;
    logic [CW-1:0]      next_col;
    logic [CW-1:0]      rd_addr;
    t_pos               pos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width   <= WIDTH_RST;
            r_map_height  <= HEIGHT_RST;
            r_min_unknown <= MINU_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH: begin
                    r_map_width <= i_cfg_data;
                end
                CFG_MAP_HEIGHT: begin
                    r_map_height <= i_cfg_data;
                end
                CFG_MIN_UNKNOWN: begin
                    r_min_unknown <= i_cfg_data[MINU_W-1:0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // window stage frees up when its item moves on or is dropped
    assign o_cell_ready = !r_a_valid || take;
    assign accept       = i_cell_valid && o_cell_ready;
    assign cur_cls      = classify(i_cell_value);

    // on an accept, look up the column the next item will need
    assign rd_addr = accept ? next_col : col;

    ofd_raster_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (accept),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .o_col        (col),
        .o_next_col   (next_col),
        .o_pos        (pos)
    );

    // upper row takes the old middle, middle takes the new cell
    ofd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_lines (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_wr_addr (col),
        .i_wr_up   (mid_cls),
        .i_wr_mid  (cur_cls),
        .i_rd_addr (rd_addr),
        .o_up      (up_cls),
        .o_mid     (mid_cls)
    );

    // oldest column drops off the top of the window
    assign n_win = {r_win[WIN_W-3*CLS_W-1:0], up_cls, mid_cls, cur_cls};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (take) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
            r_pos <= pos;
        end
    end

    ofd_frontier_eval u_eval (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_a_valid        (r_a_valid),
        .i_win            (r_win),
        .i_pos            (r_pos),
        .i_min_unknown    (r_min_unknown),
        .i_res_ready      (i_res_ready),
        .o_take           (take),
        .o_res_valid      (o_res_valid),
        .o_frontier_col   (o_frontier_col),
        .o_frontier_row   (o_frontier_row),
        .o_found          (o_found),
        .o_map_done       (o_map_done),
        .o_frontier_total (o_frontier_total)
    );

    // a result without a frontier exists only as the done marker
    a_res_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_found |-> o_map_done)
        else $error("result with neither frontier nor done");

    a_res_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_found |-> (o_frontier_col == '0) && (o_frontier_row == '0))
        else $error("position set on a result without frontier");

    a_total_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_found |-> o_frontier_total != '0)
        else $error("frontier reported with zero total");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid && !r_a_valid)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ rtl/ofd_line_store.sv @@
// ----------------------------------------------------------------------------
// ofd_line_store
// two row buffers of cell classes, read one column ahead of the stream
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [AW-1:0]                 i_wr_addr,
    input  ofd_pkg::t_cls                i_wr_up,
    input  ofd_pkg::t_cls                i_wr_mid,
    input  wire [AW-1:0]                 i_rd_addr,
    output ofd_pkg::t_cls                o_up,
    output ofd_pkg::t_cls                o_mid
);
    import ofd_pkg::*;

    t_cls r_upper_mem  [DEPTH];
    t_cls r_middle_mem [DEPTH];
    t_cls r_up;
    t_cls r_mid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_upper_mem[i_wr_addr]  <= i_wr_up;
            r_middle_mem[i_wr_addr] <= i_wr_mid;
        end
    end

    // same-address bypass covers one-column maps
    always_ff @(posedge i_clk) begin
        if (i_we && (i_rd_addr == i_wr_addr)) begin
            r_up  <= i_wr_up;
            r_mid <= i_wr_mid;
        end else begin
            r_up  <= r_upper_mem[i_rd_addr];
            r_mid <= r_middle_mem[i_rd_addr];
        end
    end

    assign o_up  = r_up;
    assign o_mid = r_mid;

endmodule

`default_nettype wire

@@ rtl/ofd_raster_ctrl.sv @@
// ----------------------------------------------------------------------------
// ofd_raster_ctrl
// column and row counters, size clamping and window centre position
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_raster_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CW         = 10,
    parameter int RW         = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_advance,
    input  wire [ofd_pkg::CFG_W-1:0]     i_map_width,
    input  wire [ofd_pkg::CFG_W-1:0]     i_map_height,
    output logic [CW-1:0]                o_col,
    output logic [CW-1:0]                o_next_col,
    output ofd_pkg::t_pos                o_pos
);
    import ofd_pkg::*;

    localparam int CMPW_C = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int CMPW_R = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [CW-1:0] w_m1;
    logic [RW-1:0] h_m1;
    logic          row_end;
    logic          last;

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (i_map_width == '0) begin
            w_m1 = '0;
        end else if (CMPW_C'(i_map_width) > CMPW_C'(MAX_WIDTH)) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(i_map_width - 11'd1);
        end
        if (i_map_height == '0) begin
            h_m1 = '0;
        end else if (CMPW_R'(i_map_height) > CMPW_R'(MAX_HEIGHT)) begin
            h_m1 = RW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = RW'(i_map_height - 11'd1);
        end
    end

    always_comb begin
        row_end = (r_col >= w_m1);
        last    = row_end && (r_row >= h_m1);
        n_col   = row_end ? '0 : r_col + CW'(1);
        if (last) begin
            n_row = '0;
        end else if (row_end) begin
            n_row = r_row + RW'(1);
        end else begin
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_pos.interior = (r_col >= CW'(2)) && (r_row >= RW'(2))
                         && (r_col <= w_m1) && (r_row <= h_m1);
        o_pos.last     = last;
        o_pos.col      = COORD_W'(r_col - CW'(1));
        o_pos.row      = COORD_W'(r_row - RW'(1));
    end

    assign o_col      = r_col;
    assign o_next_col = n_col;

endmodule

`default_nettype wire

@@ rtl/ofd_frontier_eval.sv @@
// ----------------------------------------------------------------------------
// ofd_frontier_eval
// frontier test on the registered window, running total and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_frontier_eval (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_a_valid,
    input  wire [ofd_pkg::WIN_W-1:0]     i_win,
    input  ofd_pkg::t_pos                i_pos,
    input  wire [ofd_pkg::MINU_W-1:0]    i_min_unknown,
    input  wire                          i_res_ready,
    output logic                         o_take,
    output logic                         o_res_valid,
    output logic [ofd_pkg::COORD_W-1:0]  o_frontier_col,
    output logic [ofd_pkg::COORD_W-1:0]  o_frontier_row,
    output logic                         o_found,
    output logic                         o_map_done,
    output logic [ofd_pkg::TOTAL_W-1:0]  o_frontier_total
);
    import ofd_pkg::*;

    logic [8:0]          unk_vec;
    logic [MINU_W-1:0]   unk_cnt;
    logic                found;
    logic                has_res;
    logic                out_free;
    logic [TOTAL_W-1:0]  total_inc;

    logic [TOTAL_W-1:0]  r_count;
    logic                r_valid;
    logic [COORD_W-1:0]  r_col;
    logic [COORD_W-1:0]  r_row;
    logic                r_found;
    logic                r_done;
    logic [TOTAL_W-1:0]  r_total;

    // slot four is the centre
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            unk_vec[k] = (k != 4) && (i_win[k*CLS_W +: CLS_W] == CLS_UNKNOWN);
        end
        unk_cnt = MINU_W'($countones(unk_vec));
        found   = i_pos.interior && (i_win[4*CLS_W +: CLS_W] == CLS_FREE)
                  && (unk_cnt >= i_min_unknown);
        has_res = found || i_pos.last;
        out_free = !r_valid || i_res_ready;
        o_take  = i_a_valid && (!has_res || out_free);
        total_inc = (found && (r_count != TOTAL_MAX)) ? r_count + TOTAL_W'(1)
                                                      : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_count <= i_pos.last ? '0 : total_inc;
            end
            if (o_take && has_res) begin
                r_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && has_res) begin
            r_col   <= found ? i_pos.col : '0;
            r_row   <= found ? i_pos.row : '0;
            r_found <= found;
            r_done  <= i_pos.last;
            r_total <= total_inc;
        end
    end

    assign o_res_valid      = r_valid;
    assign o_frontier_col   = r_col;
    assign o_frontier_row   = r_row;
    assign o_found          = r_found;
    assign o_map_done       = r_done;
    assign o_frontier_total = r_total;

endmodule

`default_nettype wire

@@ verif/occupancy_frontier_detector_tb.sv @@
// ----------------------------------------------------------------------------
// occupancy_frontier_detector_tb
// streams raster occupancy maps through the frontier detector and checks
// every frontier report and end-of-map marker against a cycle-free
// prediction of the window, the line stores and the per-map total; map
// size and threshold change between maps and, within the safe limits,
// in the middle of a map, under random and long back-pressure
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_frontier_detector_tb;

    import ofd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 11;
    localparam int GRID_MAX_W       = 1024;
    localparam int GRID_MAX_H       = 1024;
    localparam int DRAIN_CYCLES     = 4;
    localparam int RUN_LIMIT_CYCLES = 400000;
    localparam int SMALL_MAP_ITEMS  = 1100;
    localparam int MAX_MISMATCH_LOG = 50;

    // cell codes as they arrive on the stream
    localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;
    localparam logic signed [CELL_W-1:0] CELL_FREE    = 8'sd0;

    // register index with no register behind it; writes must be ignored
    localparam logic [CIDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // one result item as the block reports it
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               found;
        logic               done;
        logic [TOTAL_W-1:0] total;
    } t_frontier_report;

    // ------------------------------------------------------------------------
    // frontier prediction and report checking
    // ------------------------------------------------------------------------
    class t_frontier_scoreboard;
        t_cls               upper_cls [GRID_MAX_W];
        t_cls               middle_cls[GRID_MAX_W];
        logic [WIN_W-1:0]   window;
        int unsigned        col_count;
        int unsigned        row_count;
        logic [TOTAL_W-1:0] found_total;
        logic [CFG_W-1:0]   width_reg;
        logic [CFG_W-1:0]   height_reg;
        logic [MINU_W-1:0]  min_unknown_reg;
        t_frontier_report   expected_reports[$];
        int                 errors;

        function new();
            foreach (upper_cls[i]) begin
                upper_cls[i]  = CLS_FREE;
                middle_cls[i] = CLS_FREE;
            end
            window          = '0;
            col_count       = 0;
            row_count       = 0;
            found_total     = '0;
            width_reg       = WIDTH_RST;
            height_reg      = HEIGHT_RST;
            min_unknown_reg = MINU_RST;
            errors          = 0;
        endfunction

        // zero acts as one, anything past the maximum as the maximum
        function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned limit);
            if (v == 0) begin
                return 1;
            end
            return (v > limit) ? limit : int'(v);
        endfunction

        function int unsigned eff_width();
            return clamp_size(width_reg, GRID_MAX_W);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MAP_WIDTH:   width_reg       = data;
                CFG_MAP_HEIGHT:  height_reg      = data;
                CFG_MIN_UNKNOWN: min_unknown_reg = data[MINU_W-1:0];
                default: ;
            endcase
        endfunction

        function t_cls cell_class(logic signed [CELL_W-1:0] v);
            if (v == CELL_UNKNOWN) begin
                return CLS_UNKNOWN;
            end
            return (v == CELL_FREE) ? CLS_FREE : CLS_OCCUPIED;
        endfunction

        // oldest window column in the top bits, top row first within a column
        function t_cls window_at(int unsigned wc, int unsigned wr);
            logic [WIN_W-1:0] s;
            s = window >> ((2 - wc) * 6 + (2 - wr) * 2);
            return t_cls'(s[CLS_W-1:0]);
        endfunction

        // advance by one cell; returns 1 when the cell closes the map
        function bit note_cell(logic signed [CELL_W-1:0] v);
            int unsigned      w, h, c, r, n, i, j;
            t_cls             cur, up, mid;
            bit               hit, last;
            t_frontier_report rep;
            w   = eff_width();
            h   = clamp_size(height_reg, GRID_MAX_H);
            c   = col_count;
            r   = row_count;
            cur = cell_class(v);
            up  = CLS_FREE;
            mid = CLS_FREE;
            if (c < GRID_MAX_W) begin
                up            = upper_cls[c];
                mid           = middle_cls[c];
                upper_cls[c]  = mid;
                middle_cls[c] = cur;
            end
            window = {window[WIN_W-7:0], up, mid, cur};

            hit = 1'b0;
            n   = 0;
            if (c >= 2 && r >= 2 && c <= w - 1 && r <= h - 1 &&
                window_at(1, 1) == CLS_FREE) begin
                for (i = 0; i < 3; i++) begin
                    for (j = 0; j < 3; j++) begin
                        if (!(i == 1 && j == 1) && window_at(i, j) == CLS_UNKNOWN) begin
                            n++;
                        end
                    end
                end
                if (n >= min_unknown_reg) begin
                    hit = 1'b1;
                    if (found_total != TOTAL_MAX) begin
                        found_total++;
                    end
                end
            end
            last = (c >= w - 1) && (r >= h - 1);

            if (hit || last) begin
                rep.col   = hit ? COORD_W'(c - 1) : '0;
                rep.row   = hit ? COORD_W'(r - 1) : '0;
                rep.found = hit;
                rep.done  = last;
                rep.total = found_total;
                expected_reports = {expected_reports, rep};
            end

            if (c >= w - 1) begin
                col_count = 0;
                row_count = last ? 0 : r + 1;
            end else begin
                col_count = c + 1;
            end
            if (last) begin
                found_total = '0;
            end
            return last;
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                if (errors <= MAX_MISMATCH_LOG) begin
                    $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
                end
            end
        endfunction

        function void check_result(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                   logic found, logic done, logic [TOTAL_W-1:0] total);
            t_frontier_report e;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= MAX_MISMATCH_LOG) begin
                    $display("%0t: expected no result, got col %0d row %0d %0b %0b total %0d",
                             $time, col, row, found, done, total);
                end
                return;
            end
            e = expected_reports.pop_front();
            compare_field("frontier_col", e.col, col);
            compare_field("frontier_row", e.row, row);
            compare_field("found", e.found, found);
            compare_field("map_done", e.done, done);
            compare_field("frontier_total", e.total, total);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test, every input known from time zero
    // ------------------------------------------------------------------------
    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_cell_valid = 1'b0;
    logic signed [CELL_W-1:0]  i_cell_value = '0;
    logic                      i_res_ready  = 1'b0;
    logic                      i_cfg_valid  = 1'b0;
    logic [CIDX_W-1:0]         i_cfg_index  = '0;
    logic [CFG_W-1:0]          i_cfg_data   = '0;
    logic                      o_cell_ready;
    logic                      o_res_valid;
    logic [COORD_W-1:0]        o_frontier_col;
    logic [COORD_W-1:0]        o_frontier_row;
    logic                      o_found;
    logic                      o_map_done;
    logic [TOTAL_W-1:0]        o_frontier_total;
    logic                      o_cfg_ready;

    occupancy_frontier_detector #(
        .MAX_WIDTH  (GRID_MAX_W),
        .MAX_HEIGHT (GRID_MAX_H)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cell_valid     (i_cell_valid),
        .o_cell_ready     (o_cell_ready),
        .i_cell_value     (i_cell_value),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_frontier_col   (o_frontier_col),
        .o_frontier_row   (o_frontier_row),
        .o_found          (o_found),
        .o_map_done       (o_map_done),
        .o_frontier_total (o_frontier_total),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    t_frontier_scoreboard sb = new();

    // idling levels in percent per cycle, changed by the stimulus
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // long receiver hold-off, requested by the stimulus, counted down below
    int unsigned res_hold_req   = 0;
    int unsigned res_hold_left  = 0;
    int unsigned cells_in_small_maps = 0;

    // 3x3 maps for the directed part
    logic signed [CELL_W-1:0] ring_cells [9] = '{
        -8'sd1, -8'sd1, -8'sd1,
        -8'sd1,  8'sd0, -8'sd1,
        -8'sd1, -8'sd1, -8'sd1
    };
    logic signed [CELL_W-1:0] mixed_cells [9] = '{
        8'sd127, -8'sd128, 8'sd1,
        8'sd100,  8'sd0,  -8'sd1,
        8'sd2,    8'sd64, -8'sd2
    };

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (res_hold_req != 0) begin
            res_hold_left = res_hold_req;
            res_hold_req  = 0;
        end
        if (res_hold_left != 0) begin
            res_hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor: outputs sampled at the rising edge, before they update
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            sb.check_result(o_frontier_col, o_frontier_row, o_found, o_map_done,
                            o_frontier_total);
        end
    end

    // ------------------------------------------------------------------------
    // driving tasks; all start and end at a falling edge
    // ------------------------------------------------------------------------

    // offer one cell item, hold it until taken, then update the prediction;
    // valid is left high so the next item can follow without a gap
    task automatic send_cell(input logic signed [CELL_W-1:0] v, output bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_cell_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cell_valid <= 1'b1;
        i_cell_value <= v;
        do @(posedge i_clk); while (!o_cell_ready);
        last = sb.note_cell(v);
        @(negedge i_clk);
    endtask

    // stop the stream, wait for every outstanding report, then let the
    // pipeline empty of items that yield nothing
    task automatic wait_idle();
        i_cell_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // one register write; valid stays high for a following write
    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data,
                             input logic [CFG_W-1:0] mu_data);
        wait_idle();
        cfg_write(CFG_MAP_WIDTH, w_data);
        cfg_write(CFG_MAP_HEIGHT, h_data);
        cfg_write(CFG_MIN_UNKNOWN, mu_data);
        i_cfg_valid <= 1'b0;
    endtask

    // threshold mostly in 0..8, sometimes beyond; spare upper data bits random
    function automatic logic [CFG_W-1:0] random_min_unknown();
        logic [CFG_W-1:0] d;
        d = CFG_W'($urandom);
        d[MINU_W-1:0] = ($urandom_range(9) == 0) ? MINU_W'($urandom_range(9, 15))
                                                 : MINU_W'($urandom_range(0, 8));
        return d;
    endfunction

    function automatic logic signed [CELL_W-1:0] random_cell(int unsigned p_unknown,
                                                             int unsigned p_free);
        int unsigned x;
        x = $urandom_range(99);
        if (x < p_unknown) begin
            return CELL_UNKNOWN;
        end else if (x < p_unknown + p_free) begin
            return CELL_FREE;
        end
        return CELL_W'($urandom);
    endfunction

    // mid-map change: new height and threshold, width never grows so that
    // every line-store entry the window uses was written in this map
    task automatic reshape_mid_map();
        logic [CFG_W-1:0] w_data;
        w_data = $urandom_range(1) ? CFG_W'($urandom_range(0, sb.eff_width()))
                                   : CFG_W'(sb.eff_width());
        configure(w_data, CFG_W'($urandom_range(0, 9)), random_min_unknown());
    endtask

    // stream cells until the prediction sees the map close
    task automatic feed_map(input int unsigned p_unknown, input int unsigned p_free,
                            input int split_at, output int fed);
        bit last;
        last = 1'b0;
        fed  = 0;
        while (!last) begin
            if (fed == split_at) begin
                reshape_mid_map();
            end
            send_cell(random_cell(p_unknown, p_free), last);
            fed++;
        end
    endtask

    task automatic run_random_map();
        logic [CFG_W-1:0] w_data, h_data;
        int unsigned      pick, p_unknown;
        int               split_at, fed;
        pick = $urandom_range(99);
        if (pick < 8) begin
            w_data = '0;
        end else if (pick < 20) begin
            w_data = CFG_W'($urandom_range(11, 30));
        end else begin
            w_data = CFG_W'($urandom_range(1, 10));
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
            h_data = '0;
        end else if (pick < 20) begin
            h_data = CFG_W'($urandom_range(9, 16));
        end else begin
            h_data = CFG_W'($urandom_range(1, 8));
        end
        configure(w_data, h_data, random_min_unknown());
        p_unknown = $urandom_range(5, 70);
        split_at  = ($urandom_range(3) == 0) ? int'($urandom_range(1, 40)) : -1;
        feed_map(p_unknown, $urandom_range(0, 100 - p_unknown), split_at, fed);
        cells_in_small_maps += fed;
    endtask

    task automatic directed_maps();
        bit last;
        // free centre with all eight neighbours unknown, threshold at eight
        configure(11'd3, 11'd3, 11'd8);
        foreach (ring_cells[i]) send_cell(ring_cells[i], last);
        // threshold beyond eight: nothing can qualify
        configure(11'd3, 11'd3, 11'd9);
        foreach (ring_cells[i]) send_cell(ring_cells[i], last);
        // threshold zero, value extremes around a free centre
        configure(11'd3, 11'd3, 11'd0);
        wait_idle();
        cfg_write(CFG_IDX_SPARE, '1);
        i_cfg_valid <= 1'b0;
        foreach (mixed_cells[i]) send_cell(mixed_cells[i], last);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int fed;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_maps();

        // sender barely idles, receiver stalls half the time
        send_idle_pct  = 6;
        recv_stall_pct = 52;
        while (cells_in_small_maps < SMALL_MAP_ITEMS / 3) run_random_map();

        // the other way round
        send_idle_pct  = 52;
        recv_stall_pct = 6;
        while (cells_in_small_maps < 2 * SMALL_MAP_ITEMS / 3) run_random_map();

        // no idling; first an all-free map with threshold zero while the
        // receiver holds off, so reports back up and the cell input stalls
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(11'd12, 11'd10, 11'd0);
        res_hold_req = 300;
        feed_map(0, 100, -1, fed);
        cells_in_small_maps += fed;
        while (cells_in_small_maps < SMALL_MAP_ITEMS) run_random_map();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** occupancy_frontier_detector: PASSED **");
        end else begin
            $display("** occupancy_frontier_detector: FAILED **");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("** occupancy_frontier_detector: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
